// File: rtl/cnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_pkg: shared types and constants of the Chinese numeral parser
// Payload structs, glyph decode table, ALU and sequencer codes.
// ----------------------------------------------------------------------------
package cnp_pkg;

    localparam int VAL_W  = 63;
    localparam int CODE_W = 16;
    localparam int DIG_W  = 4;
    localparam int CNT_W  = 4;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam val_t VAL_MAX = {VAL_W{1'b1}};
    localparam val_t VAL_ONE = val_t'(1);

    // number of times-ten steps for the 10^4 and 10^8 units
    localparam cnt_t MUL_WAN = cnt_t'(4);
    localparam cnt_t MUL_YI  = cnt_t'(8);

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        val_t value;
        logic invalid;
        logic overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_UNIT,
        KIND_WAN,
        KIND_YI
    } kind_t;

    // for digits val is the digit, for small units the power of ten
    typedef struct packed {
        logic             known;
        kind_t            kind;
        logic [DIG_W-1:0] val;
    } glyph_t;

    typedef enum logic {
        ALU_ADD,
        ALU_MUL10
    } alu_op_t;

    typedef enum logic [2:0] {
        A_ACC,
        A_PEND,
        A_SECT,
        A_HIGH,
        A_RUN
    } a_sel_t;

    typedef enum logic [2:0] {
        B_ZERO,
        B_DIGIT,
        B_PEND,
        B_SECT,
        B_HIGH
    } b_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIG_MUL,
        ST_DIG_ADD,
        ST_UNIT_LOAD,
        ST_SEC_LOAD,
        ST_MUL,
        ST_UNIT_ADD,
        ST_WAN_STORE,
        ST_YI_STORE,
        ST_YI_HADD,
        ST_FIN_A,
        ST_FIN_B
    } state_t;

    typedef struct packed {
        alu_op_t          op;
        a_sel_t           a_sel;
        b_sel_t           b_sel;
        logic [DIG_W-1:0] digit;
        logic             acc_we;
        logic             p_we;
        logic             p_clr;
        logic             s_we_res;
        logic             s_we_acc;
        logic             s_clr;
        logic             h_we;
        logic             ovf_en;
        logic             out_load;
        logic             clr_all;
        logic             bad;
    } ctrl_t;

    function automatic glyph_t decode_glyph(input logic [CODE_W-1:0] code);
        glyph_t g;
        g.known = 1'b1;
        g.kind  = KIND_DIGIT;
        g.val   = '0;
        unique case (code)
            16'h96F6: g.val = 4'd0;
            16'h4E00, 16'h58F9: g.val = 4'd1;
            16'h4E8C, 16'h4E24, 16'h4FE9, 16'h8D30: g.val = 4'd2;
            16'h4E09, 16'h53C1: g.val = 4'd3;
            16'h56DB, 16'h8086: g.val = 4'd4;
            16'h4E94, 16'h4F0D: g.val = 4'd5;
            16'h516D, 16'h9646: g.val = 4'd6;
            16'h4E03, 16'h67D2: g.val = 4'd7;
            16'h516B, 16'h634C: g.val = 4'd8;
            16'h4E5D, 16'h7396: g.val = 4'd9;
            16'h5341, 16'h62FE: begin
                g.kind = KIND_UNIT;
                g.val  = 4'd1;
            end
            16'h767E, 16'h4F70: begin
                g.kind = KIND_UNIT;
                g.val  = 4'd2;
            end
            16'h5343, 16'h4EDF: begin
                g.kind = KIND_UNIT;
                g.val  = 4'd3;
            end
            16'h4E07, 16'h842C: g.kind = KIND_WAN;
            16'h4EBF, 16'h5104: g.kind = KIND_YI;
            default: g.known = 1'b0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

// File: rtl/cnp_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_alu: shared saturating arithmetic unit
// Computes a + b or a * 10, clamped to the 63-bit maximum with an overflow flag.
// ----------------------------------------------------------------------------
module cnp_alu (
    input  cnp_pkg::alu_op_t op,
    input  cnp_pkg::val_t    a,
    input  cnp_pkg::val_t    b,
    output cnp_pkg::val_t    res,
    output logic             ovf
);
    import cnp_pkg::*;

    logic [VAL_W:0]   sum;
    logic [VAL_W+3:0] prod;

    // times ten as eight a plus two a
    assign sum  = {1'b0, a} + {1'b0, b};
    assign prod = {1'b0, a, 3'b000} + {3'b000, a, 1'b0};

    always_comb begin
        unique case (op)
            ALU_ADD: begin
                ovf = sum[VAL_W];
                res = ovf ? VAL_MAX : sum[VAL_W-1:0];
            end
            ALU_MUL10: begin
                ovf = |prod[VAL_W+3:VAL_W];
                res = ovf ? VAL_MAX : prod[VAL_W-1:0];
            end
            default: begin
                ovf = 1'b0;
                res = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/cnp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_ctrl: character sequencer
// Decodes each accepted character and steps the shared ALU through its work.
// ----------------------------------------------------------------------------
module cnp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cnp_pkg::in_item_t s_payload,
    input  logic              m_stall,
    output cnp_pkg::ctrl_t    ctl
);
    import cnp_pkg::*;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [DIG_W-1:0] val_reg, val_next;
    logic             last_reg, last_next;
    cnt_t             cnt_reg, cnt_next;
    logic             hi_reg, hi_next;
    logic             bad_reg, bad_next;
    glyph_t           glyph;
    state_t           done_state;

    assign glyph      = decode_glyph(s_payload.char_code);
    assign done_state = last_reg ? ST_FIN_A : ST_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_DIGIT;
            val_reg   <= '0;
            last_reg  <= 1'b0;
            cnt_reg   <= '0;
            hi_reg    <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            val_reg   <= val_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            hi_reg    <= hi_next;
            bad_reg   <= bad_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        bad_next   = bad_reg;
        s_ready    = 1'b0;
        ctl          = '0;
        ctl.op       = ALU_ADD;
        ctl.a_sel    = A_ACC;
        ctl.b_sel    = B_ZERO;
        ctl.digit    = val_reg;
        ctl.bad      = bad_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next = glyph.kind;
                    val_next  = glyph.val;
                    last_next = s_payload.last_char;
                    hi_next   = 1'b0;
                    if (!glyph.known) begin
                        bad_next = 1'b1;
                    end
                    if (glyph.known && !bad_reg) begin
                        unique case (glyph.kind)
                            KIND_DIGIT: state_next = ST_DIG_MUL;
                            KIND_UNIT:  state_next = ST_UNIT_LOAD;
                            KIND_WAN:   state_next = ST_SEC_LOAD;
                            KIND_YI:    state_next = ST_SEC_LOAD;
                            default:    state_next = ST_IDLE;
                        endcase
                    end else begin
                        // frozen arithmetic: only the final sum is still due
                        state_next = s_payload.last_char ? ST_FIN_A : ST_IDLE;
                    end
                end
            end
            ST_DIG_MUL: begin
                ctl.op     = ALU_MUL10;
                ctl.a_sel  = A_PEND;
                ctl.acc_we = 1'b1;
                ctl.ovf_en = 1'b1;
                state_next = ST_DIG_ADD;
            end
            ST_DIG_ADD: begin
                ctl.b_sel  = B_DIGIT;
                ctl.p_we   = 1'b1;
                ctl.ovf_en = 1'b1;
                state_next = done_state;
            end
            ST_UNIT_LOAD: begin
                ctl.a_sel  = A_RUN;
                ctl.acc_we = 1'b1;
                cnt_next   = cnt_t'(val_reg);
                state_next = ST_MUL;
            end
            ST_SEC_LOAD: begin
                ctl.a_sel  = A_SECT;
                ctl.b_sel  = B_PEND;
                ctl.acc_we = 1'b1;
                ctl.ovf_en = 1'b1;
                cnt_next   = (kind_reg == KIND_WAN) ? MUL_WAN : MUL_YI;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                ctl.op     = ALU_MUL10;
                ctl.acc_we = 1'b1;
                ctl.ovf_en = 1'b1;
                cnt_next   = cnt_reg - cnt_t'(1);
                if (cnt_reg == cnt_t'(1)) begin
                    unique case (kind_reg)
                        KIND_UNIT: state_next = ST_UNIT_ADD;
                        KIND_WAN:  state_next = ST_WAN_STORE;
                        KIND_YI:   state_next = hi_reg ? ST_YI_HADD : ST_YI_STORE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UNIT_ADD: begin
                ctl.b_sel    = B_SECT;
                ctl.s_we_res = 1'b1;
                ctl.p_clr    = 1'b1;
                ctl.ovf_en   = 1'b1;
                state_next   = done_state;
            end
            ST_WAN_STORE: begin
                ctl.s_we_acc = 1'b1;
                ctl.p_clr    = 1'b1;
                state_next   = done_state;
            end
            ST_YI_STORE: begin
                // park the scaled section, start scaling the high part
                ctl.s_we_acc = 1'b1;
                ctl.a_sel    = A_HIGH;
                ctl.acc_we   = 1'b1;
                cnt_next     = MUL_YI;
                hi_next      = 1'b1;
                state_next   = ST_MUL;
            end
            ST_YI_HADD: begin
                ctl.b_sel  = B_SECT;
                ctl.h_we   = 1'b1;
                ctl.s_clr  = 1'b1;
                ctl.p_clr  = 1'b1;
                ctl.ovf_en = 1'b1;
                state_next = done_state;
            end
            ST_FIN_A: begin
                ctl.a_sel  = A_SECT;
                ctl.b_sel  = B_PEND;
                ctl.acc_we = 1'b1;
                ctl.ovf_en = 1'b1;
                state_next = ST_FIN_B;
            end
            ST_FIN_B: begin
                ctl.b_sel = B_HIGH;
                if (!m_stall) begin
                    ctl.out_load = 1'b1;
                    ctl.clr_all  = 1'b1;
                    bad_next     = 1'b0;
                    last_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (cnt_reg != '0))
        else $error("multiply step with exhausted count");

    a_bad_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && bad_reg) |=> (state_reg == ST_IDLE || state_reg == ST_FIN_A))
        else $error("arithmetic started after an unknown character");

    a_hadd_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_YI_HADD) |-> (hi_reg && kind_reg == KIND_YI))
        else $error("high part add outside the second hundred-million pass");

endmodule
`default_nettype wire

// File: rtl/chinese_numeral_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chinese_numeral_parser_top: Chinese numeral to integer converter
// Reads one code point per transfer and returns the value on the last one.
// ----------------------------------------------------------------------------
// One saturating add / times-ten unit does all arithmetic, stepped by a small
// sequencer, and the input is not ready while a character is being worked.
// A digit is a times-ten and an add; a unit of 10, 100 or 1000 scales the run
// by its power of ten into the section; the 10^4 unit scales the section, the
// 10^8 unit the section and the high part; the last character forms the total.
// An output register holds results, so a new numeral can start while one waits.
// ----------------------------------------------------------------------------
module chinese_numeral_parser_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cnp_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output cnp_pkg::out_item_t m_payload
);
    import cnp_pkg::*;

    ctrl_t     ctl;
    val_t      acc_reg, acc_next;
    val_t      p_reg, p_next;
    val_t      s_reg, s_next;
    val_t      h_reg, h_next;
    logic      ovf_reg, ovf_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_payload_reg, m_payload_next;
    val_t      alu_a, alu_b, alu_res, run;
    logic      alu_ovf, ovf_any;

    cnp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_stall   (m_valid_reg && !m_ready),
        .ctl       (ctl)
    );

    cnp_alu u_alu (
        .op  (ctl.op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ovf (alu_ovf)
    );

    // an empty run counts as one in front of a small unit
    assign run = (p_reg == '0) ? VAL_ONE : p_reg;

    always_comb begin
        unique case (ctl.a_sel)
            A_ACC:   alu_a = acc_reg;
            A_PEND:  alu_a = p_reg;
            A_SECT:  alu_a = s_reg;
            A_HIGH:  alu_a = h_reg;
            A_RUN:   alu_a = run;
            default: alu_a = '0;
        endcase
        unique case (ctl.b_sel)
            B_ZERO:  alu_b = '0;
            B_DIGIT: alu_b = val_t'(ctl.digit);
            B_PEND:  alu_b = p_reg;
            B_SECT:  alu_b = s_reg;
            B_HIGH:  alu_b = h_reg;
            default: alu_b = '0;
        endcase
    end

    assign ovf_any = ovf_reg || alu_ovf;

    always_comb begin
        acc_next       = ctl.acc_we ? alu_res : acc_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        h_next         = h_reg;
        ovf_next       = ovf_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;

        if (ctl.p_we) begin
            p_next = alu_res;
        end
        if (ctl.p_clr) begin
            p_next = '0;
        end
        priority if (ctl.s_clr) begin
            s_next = '0;
        end else if (ctl.s_we_res) begin
            s_next = alu_res;
        end else if (ctl.s_we_acc) begin
            s_next = acc_reg;
        end else begin
            s_next = s_reg;
        end
        if (ctl.h_we) begin
            h_next = alu_res;
        end
        if (ctl.ovf_en && alu_ovf) begin
            ovf_next = 1'b1;
        end

        if (ctl.out_load) begin
            m_valid_next            = 1'b1;
            m_payload_next.invalid  = ctl.bad;
            m_payload_next.overflow = ovf_any;
            priority if (ctl.bad) begin
                m_payload_next.value = '0;
            end else if (ovf_any) begin
                m_payload_next.value = VAL_MAX;
            end else begin
                m_payload_next.value = alu_res;
            end
        end

        if (ctl.clr_all) begin
            p_next   = '0;
            s_next   = '0;
            h_next   = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg       <= '0;
            s_reg       <= '0;
            h_reg       <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_reg       <= p_next;
            s_reg       <= s_next;
            h_reg       <= h_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten before its transfer");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |=> (p_reg == '0 && s_reg == '0 && h_reg == '0 && !ovf_reg))
        else $error("numeral state not cleared after the result");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load && ctl.bad |=> (m_payload.value == '0 && m_payload.invalid))
        else $error("invalid numeral gave a nonzero value");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load && !ctl.bad && ovf_any |=> (m_payload.value == VAL_MAX))
        else $error("overflowed numeral not saturated");

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chinese_numeral_parser_top
// Sends numerals one code point per transfer, some spelled from random values
// and some random glyph strings, broken strings and noise. Expected results
// are kept in a queue and compared field by field with every result
// transfer.
// ----------------------------------------------------------------------------
module testbench;
    import cnp_pkg::*;

    typedef logic [63:0] wide_t;
    typedef enum int {
        RECV_SLOW,
        SEND_SLOW,
        NO_IDLE
    } traffic_t;

    localparam wide_t SAT_MAX         = {1'b0, VAL_MAX};
    localparam wide_t WAN_SCALE       = 64'd10000;
    localparam wide_t YI_SCALE        = 64'd100000000;
    localparam int    LIGHT_IDLE_PCT  = 14;
    localparam int    HEAVY_IDLE_PCT  = 53;
    localparam int    STALL_AT_RESULT = 40;
    localparam int    STALL_CYCLES    = 400;
    localparam int    WATCHDOG_LIMIT  = 3000;
    localparam int    TAIL_CYCLES     = 40;
    localparam int    ITEMS_PER_PHASE = 630;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;

    traffic_t    traffic = RECV_SLOW;
    in_item_t    char_queue[$];
    out_item_t   expected_results[$];
    logic [15:0] numeral_codes[$];
    int          items_queued = 0;

    // parser state as predicted
    wide_t run_acc      = '0;
    wide_t section_acc  = '0;
    wide_t high_acc     = '0;
    bit    saw_bad_char = 1'b0;
    bit    saw_overflow = 1'b0;

    int error_count  = 0;
    int results_seen = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    chinese_numeral_parser_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // plain digits 0-9, formal 1-9, the two other twos, plain and formal
    // small units, then the two forms of ten thousand and of hundred million
    function automatic logic [15:0] glyph_code(int idx);
        case (idx)
            0:  return 16'h96F6;
            1:  return 16'h4E00;
            2:  return 16'h4E8C;
            3:  return 16'h4E09;
            4:  return 16'h56DB;
            5:  return 16'h4E94;
            6:  return 16'h516D;
            7:  return 16'h4E03;
            8:  return 16'h516B;
            9:  return 16'h4E5D;
            10: return 16'h58F9;
            11: return 16'h8D30;
            12: return 16'h53C1;
            13: return 16'h8086;
            14: return 16'h4F0D;
            15: return 16'h9646;
            16: return 16'h67D2;
            17: return 16'h634C;
            18: return 16'h7396;
            19: return 16'h4E24;
            20: return 16'h4FE9;
            21: return 16'h5341;
            22: return 16'h767E;
            23: return 16'h5343;
            24: return 16'h62FE;
            25: return 16'h4F70;
            26: return 16'h4EDF;
            27: return 16'h4E07;
            28: return 16'h842C;
            29: return 16'h4EBF;
            default: return 16'h5104;
        endcase
    endfunction

    function automatic wide_t pow10(int e);
        wide_t p = 64'd1;
        repeat (e) p = p * 10;
        return p;
    endfunction

    function automatic void decode_char(input logic [15:0] code, output bit known,
                                        output kind_t kind, output wide_t weight);
        known  = 1'b0;
        kind   = KIND_DIGIT;
        weight = '0;
        for (int i = 0; i < 31; i++) begin
            if (glyph_code(i) == code) begin
                known = 1'b1;
                if (i <= 9) begin
                    weight = wide_t'(i);
                end else if (i <= 18) begin
                    weight = wide_t'(i - 9);
                end else if (i <= 20) begin
                    weight = 64'd2;
                end else if (i <= 26) begin
                    kind   = KIND_UNIT;
                    weight = pow10(i <= 23 ? i - 20 : i - 23);
                end else if (i <= 28) begin
                    kind = KIND_WAN;
                end else begin
                    kind = KIND_YI;
                end
            end
        end
    endfunction

    function automatic wide_t sat_sum(wide_t a, wide_t b);
        if (a > SAT_MAX || b > SAT_MAX || a > SAT_MAX - b) begin
            saw_overflow = 1'b1;
            return SAT_MAX;
        end
        return a + b;
    endfunction

    function automatic wide_t sat_scale(wide_t a, wide_t k);
        if (k != 0 && a > SAT_MAX / k) begin
            saw_overflow = 1'b1;
            return SAT_MAX;
        end
        return a * k;
    endfunction

    function automatic void parse_char(in_item_t item);
        bit        known;
        kind_t     kind;
        wide_t     weight;
        wide_t     run;
        wide_t     sect;
        wide_t     total;
        out_item_t res;
        decode_char(item.char_code, known, kind, weight);
        if (!known) begin
            saw_bad_char = 1'b1;
        end else if (!saw_bad_char) begin
            case (kind)
                KIND_DIGIT: begin
                    run_acc = sat_sum(sat_scale(run_acc, 64'd10), weight);
                end
                KIND_UNIT: begin
                    // an empty or all-zero run stands for one
                    run         = (run_acc == 0) ? 64'd1 : run_acc;
                    section_acc = sat_sum(section_acc, sat_scale(run, weight));
                    run_acc     = '0;
                end
                KIND_WAN: begin
                    section_acc = sat_scale(sat_sum(section_acc, run_acc), WAN_SCALE);
                    run_acc     = '0;
                end
                default: begin
                    sect        = sat_scale(sat_sum(section_acc, run_acc), YI_SCALE);
                    high_acc    = sat_sum(sat_scale(high_acc, YI_SCALE), sect);
                    section_acc = '0;
                    run_acc     = '0;
                end
            endcase
        end
        if (item.last_char) begin
            // the final sum may itself saturate, even for an invalid numeral
            total = sat_sum(sat_sum(section_acc, run_acc), high_acc);
            if (saw_bad_char) begin
                total = '0;
            end else if (saw_overflow) begin
                total = SAT_MAX;
            end
            res.value    = total[62:0];
            res.invalid  = saw_bad_char;
            res.overflow = saw_overflow;
            expected_results.push_back(res);
            run_acc      = '0;
            section_acc  = '0;
            high_acc     = '0;
            saw_bad_char = 1'b0;
            saw_overflow = 1'b0;
        end
    endfunction

    function automatic void commit_numeral();
        in_item_t item;
        foreach (numeral_codes[i]) begin
            item.char_code = numeral_codes[i];
            item.last_char = (i == numeral_codes.size() - 1);
            char_queue.push_back(item);
        end
        items_queued += numeral_codes.size();
        numeral_codes.delete();
    endfunction

    function automatic logic [15:0] digit_glyph(int d, bit formal);
        if (d == 2 && $urandom_range(3) == 0) begin
            return glyph_code(19 + $urandom_range(1));
        end
        if (d == 0 || !formal) begin
            return glyph_code(d);
        end
        return glyph_code(9 + d);
    endfunction

    // spells 0..9999 with zero fill between nonzero places
    function automatic void spell_group(int unsigned v, bit formal);
        int unsigned d;
        int unsigned scale   = 1000;
        bit          emitted = 1'b0;
        bit          gap     = 1'b0;
        for (int p = 3; p >= 0; p--) begin
            d = (v / scale) % 10;
            if (d != 0) begin
                if (gap) begin
                    numeral_codes.push_back(glyph_code(0));
                end
                // leading one before ten is often left out
                if (!(p == 1 && d == 1 && !emitted && $urandom_range(1) == 1)) begin
                    numeral_codes.push_back(digit_glyph(d, formal));
                end
                if (p > 0) begin
                    numeral_codes.push_back(glyph_code(formal ? 23 + p : 20 + p));
                end
                emitted = 1'b1;
                gap     = 1'b0;
            end else if (emitted) begin
                gap = 1'b1;
            end
            scale = scale / 10;
        end
    endfunction

    function automatic void spell_below_yi(wide_t v, bit formal);
        if (v / WAN_SCALE != 0) begin
            spell_group(int'(v / WAN_SCALE), formal);
            numeral_codes.push_back(glyph_code(27 + formal));
        end
        if (v % WAN_SCALE != 0) begin
            if (v >= WAN_SCALE && v % WAN_SCALE < 1000) begin
                numeral_codes.push_back(glyph_code(0));
            end
            spell_group(int'(v % WAN_SCALE), formal);
        end
    endfunction

    function automatic void spell_number(wide_t n, bit formal);
        if (n == 0) begin
            numeral_codes.push_back(glyph_code(0));
            return;
        end
        if (n >= YI_SCALE) begin
            spell_below_yi(n / YI_SCALE, formal);
            numeral_codes.push_back(glyph_code(29 + formal));
        end
        if (n % YI_SCALE != 0) begin
            if (n >= YI_SCALE && n % YI_SCALE < 10000000) begin
                numeral_codes.push_back(glyph_code(0));
            end
            spell_below_yi(n % YI_SCALE, formal);
        end
    endfunction

    // any mix of known glyphs, long ones run into saturation
    function automatic void soup_numeral(int len);
        int unsigned pick;
        repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                numeral_codes.push_back(glyph_code($urandom_range(20)));
            end else if (pick < 80) begin
                numeral_codes.push_back(glyph_code($urandom_range(26, 21)));
            end else if (pick < 90) begin
                numeral_codes.push_back(glyph_code($urandom_range(28, 27)));
            end else begin
                numeral_codes.push_back(glyph_code($urandom_range(30, 29)));
            end
        end
    endfunction

    function automatic void fill_random(int count);
        int          target = items_queued + count;
        int unsigned pick;
        bit          formal;
        while (items_queued < target) begin
            pick   = $urandom_range(99);
            formal = $urandom_range(1);
            if (pick < 60) begin
                spell_number({$urandom, $urandom} % pow10($urandom_range(16, 1)), formal);
            end else if (pick < 85) begin
                soup_numeral($urandom_range(pick < 80 ? 8 : 24, 1));
            end else if (pick < 94) begin
                // well-formed numeral with one character corrupted
                spell_number({$urandom, $urandom} % pow10($urandom_range(12, 1)), formal);
                numeral_codes[$urandom_range(numeral_codes.size() - 1)] = 16'($urandom);
            end else begin
                repeat ($urandom_range(4, 1)) numeral_codes.push_back(16'($urandom));
            end
            commit_numeral();
        end
    endfunction

    task automatic wait_drained();
        while (char_queue.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_char(s_payload);
            end
            if (!s_valid || s_ready) begin
                if (char_queue.size() != 0 && $urandom_range(99) >=
                        (traffic == RECV_SLOW ? LIGHT_IDLE_PCT :
                         traffic == SEND_SLOW ? HEAVY_IDLE_PCT : 0)) begin
                    s_valid   <= 1'b1;
                    s_payload <= char_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: value %0d invalid %0b overflow %0b",
                             $time, m_payload.value, m_payload.invalid, m_payload.overflow);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_payload.value !== want.value) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want.value, m_payload.value);
                        error_count++;
                    end
                    if (m_payload.invalid !== want.invalid) begin
                        $display("%0t: invalid mismatch: expected %0b, actual %0b",
                                 $time, want.invalid, m_payload.invalid);
                        error_count++;
                    end
                    if (m_payload.overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                                 $time, want.overflow, m_payload.overflow);
                        error_count++;
                    end
                end
                results_seen++;
                // long hold-off so the output register fills and input backs up
                if (results_seen == STALL_AT_RESULT) begin
                    stall_left = STALL_CYCLES;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(99) >=
                           (traffic == RECV_SLOW ? HEAVY_IDLE_PCT :
                            traffic == SEND_SLOW ? LIGHT_IDLE_PCT : 0);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("** chinese_numeral_parser_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // out-of-range code points, second one followed by a valid glyph
        numeral_codes = '{16'h0000};
        commit_numeral();
        numeral_codes = '{16'hFFFF, 16'h4E00};
        commit_numeral();
        // bare ten, and zero digit in front of hundred
        numeral_codes = '{16'h5341};
        commit_numeral();
        numeral_codes = '{16'h96F6, 16'h767E};
        commit_numeral();
        // formal 9999
        numeral_codes = '{16'h7396, 16'h4EDF, 16'h7396, 16'h4F70, 16'h7396, 16'h62FE,
                          16'h7396};
        commit_numeral();
        numeral_codes = '{16'h4E00, 16'h4EBF};
        commit_numeral();
        // hundred million cubed saturates
        numeral_codes = '{16'h4E5D, 16'h4EBF, 16'h5104, 16'h4EBF};
        commit_numeral();
        numeral_codes = '{16'h4F0D, 16'h842C, 16'h53C1};
        commit_numeral();

        fill_random(ITEMS_PER_PHASE);
        wait_drained();
        traffic = SEND_SLOW;
        fill_random(ITEMS_PER_PHASE);
        wait_drained();
        traffic = NO_IDLE;
        fill_random(ITEMS_PER_PHASE);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("** chinese_numeral_parser_top: PASSED **");
        end else begin
            $display("** chinese_numeral_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
